// ----- design/tgs_pkg.sv -----
// tgs_pkg: constants, types and helper functions of the trilinear grid sampler
// used by every module of the block; depends on nothing else
`timescale 1ns / 1ps

package tgs_pkg;

  // grid and number format
  localparam int FRAC_BITS   = 16;
  localparam int MAX_DIM     = 16;
  localparam int VOXEL_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(VOXEL_DEPTH);
  localparam int DATA_W      = 32;
  localparam int POS_W       = 22;
  localparam int FLOOR_W     = POS_W - FRAC_BITS;
  localparam int DIM_W       = 5;
  localparam int COORD_W     = $clog2(MAX_DIM);
  localparam int WGT_W       = FRAC_BITS + 1;
  localparam int TERM_W      = DATA_W + 1;
  localparam int CORNERS     = 8;
  localparam int CNT_W       = $clog2(CORNERS);
  localparam int ACC_W       = TERM_W + CNT_W;
  localparam int CFG_IDX_W   = 3;
  localparam int TDATA_W     = 112;

  // request kinds carried in tuser
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM_X  = 3'd0,
    REG_DIM_Y  = 3'd1,
    REG_DIM_Z  = 3'd2,
    REG_WRAP_X = 3'd3,
    REG_WRAP_Y = 3'd4,
    REG_WRAP_Z = 3'd5
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_READ
  } state_t;

  // effective grid setup (dimensions already limited to 2..MAX_DIM)
  typedef struct packed {
    logic [DIM_W-1:0] dim_x;
    logic [DIM_W-1:0] dim_y;
    logic [DIM_W-1:0] dim_z;
    logic             wrap_x;
    logic             wrap_y;
    logic             wrap_z;
  } grid_cfg_t;

  // sequencer strobes toward the address generator
  typedef struct packed {
    logic load;
    logic setup;
    logic issue;
  } seq_ctl_t;

  // one corner term on its way into the multiply pipeline
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [WGT_W-1:0] wx;
    logic [WGT_W-1:0] wy;
    logic [WGT_W-1:0] wz;
  } term_req_t;

  // limit a dimension register to 2..MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d < DIM_W'(2)) r = DIM_W'(2);
    else if (d > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else r = d;
    return r;
  endfunction

  // corner coordinate: wrap modulo dim or clamp to 0..dim-1
  // wrap: bias by a multiple of dim to go positive, then restoring remainder
  function automatic logic [COORD_W-1:0] corner_coord(
    input logic signed [FLOOR_W:0] c,
    input logic [DIM_W-1:0]        dim,
    input logic                    wrap
  );
    logic [DIM_W+FLOOR_W-1:0] v;
    logic [DIM_W+FLOOR_W-1:0] dim_ext;
    logic [DIM_W+FLOOR_W-1:0] step;
    logic [DIM_W+FLOOR_W-1:0] c_ext;
    logic [DIM_W-1:0]         dim_m1;
    logic [COORD_W-1:0]       res;
    dim_ext = {{FLOOR_W{1'b0}}, dim};
    c_ext   = {{(DIM_W-1){c[FLOOR_W]}}, c};
    dim_m1  = dim - DIM_W'(1);
    if (wrap) begin
      v = c_ext + (dim_ext << (FLOOR_W - 1));
      for (int k = FLOOR_W - 1; k >= 0; k--) begin
        step = dim_ext << k;
        if (v >= step) v = v - step;
      end
      res = v[COORD_W-1:0];
    end else if (c[FLOOR_W]) begin
      res = '0;
    end else if (c_ext >= dim_ext) begin
      res = dim_m1[COORD_W-1:0];
    end else begin
      res = c[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- design/trilinear_grid_sampler_top.sv -----
// trilinear_grid_sampler_top: request stream, configuration registers and the
// sequencer; depends on tgs_pkg, tgs_voxel_ram, tgs_addr_gen and tgs_accum
`timescale 1ns / 1ps

// Usage
// - s_axis carries requests: tuser 0 stores voxel_value at voxel_index,
//   tuser 1 samples the grid at (pos_x, pos_y, pos_z), signed Q16
// - m_axis returns one sample_value (signed Q16, saturated) per sample
//   request, in request order; writes return nothing
// - cfg_we/cfg_index/cfg_data set dim_x, dim_y, dim_z (2..16) and the
//   per-axis wrap flags; write them only while no request is in flight
// - a write request is stored as it is accepted
// - a sample request is a setup state and eight corner reads through the
//   single read port of the voxel store, then three multiply stages and
//   one accumulate; s_axis_tready stays low during setup and reads
// - back-to-back samples run one at a time: the next sample's
//   corner reads start once the multiply pipeline has drained
// - a finished result waits in the output register while m_axis_tready is
//   low; new requests are still taken, one more sample still runs and its
//   sum waits in the accumulator, and a sample after that holds before its
//   corner reads until the waiting result leaves
// - reset clears the sequencer and sets dimensions to 16, wrap off; the
//   voxel store is not cleared and must be written before it is sampled

module trilinear_grid_sampler_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // voxel_index[11:0], voxel_value[43:12], pos_x[65:44], pos_y[87:66],
  // pos_z[109:88], zero pad[111:110]
  input  logic [tgs_pkg::TDATA_W-1:0]         s_axis_tdata,
  // cmd[0]
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // sample_value[31:0]
  output logic [tgs_pkg::DATA_W-1:0]          m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [tgs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tgs_pkg::DIM_W-1:0]           cfg_data
);

  localparam int AW = tgs_pkg::ADDR_W;
  localparam int DW = tgs_pkg::DATA_W;
  localparam int PW = tgs_pkg::POS_W;
  localparam int VI_LO = 0;
  localparam int VV_LO = VI_LO + AW;
  localparam int PX_LO = VV_LO + DW;
  localparam int PY_LO = PX_LO + PW;
  localparam int PZ_LO = PY_LO + PW;

  tgs_pkg::state_t             state, state_next;
  tgs_pkg::grid_cfg_t          cfg;
  tgs_pkg::seq_ctl_t           ctl;
  tgs_pkg::term_req_t          req;
  logic [tgs_pkg::DIM_W-1:0]   dim_x, dim_y, dim_z;
  logic                        wrap_x, wrap_y, wrap_z;
  logic                        accept;
  logic                        is_sample;
  logic                        acc_busy;
  logic                        last_corner;
  logic [AW-1:0]               rd_addr;
  logic [DW-1:0]               rd_data;
  logic [AW-1:0]               voxel_index;
  logic [DW-1:0]               voxel_value;
  logic signed [PW-1:0]        pos_x, pos_y, pos_z;

  // request fields
  assign voxel_index = s_axis_tdata[VI_LO +: AW];
  assign voxel_value = s_axis_tdata[VV_LO +: DW];
  assign pos_x       = s_axis_tdata[PX_LO +: PW];
  assign pos_y       = s_axis_tdata[PY_LO +: PW];
  assign pos_z       = s_axis_tdata[PZ_LO +: PW];
  assign accept      = s_axis_tvalid && s_axis_tready;
  assign is_sample   = (s_axis_tuser == tgs_pkg::CMD_SAMPLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_x  <= tgs_pkg::DIM_W'(tgs_pkg::MAX_DIM);
      dim_y  <= tgs_pkg::DIM_W'(tgs_pkg::MAX_DIM);
      dim_z  <= tgs_pkg::DIM_W'(tgs_pkg::MAX_DIM);
      wrap_x <= 1'b0;
      wrap_y <= 1'b0;
      wrap_z <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        tgs_pkg::REG_DIM_X:  dim_x  <= cfg_data;
        tgs_pkg::REG_DIM_Y:  dim_y  <= cfg_data;
        tgs_pkg::REG_DIM_Z:  dim_z  <= cfg_data;
        tgs_pkg::REG_WRAP_X: wrap_x <= cfg_data[0];
        tgs_pkg::REG_WRAP_Y: wrap_y <= cfg_data[0];
        tgs_pkg::REG_WRAP_Z: wrap_z <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective grid setup
  always_comb begin
    cfg.dim_x  = tgs_pkg::eff_dim(dim_x);
    cfg.dim_y  = tgs_pkg::eff_dim(dim_y);
    cfg.dim_z  = tgs_pkg::eff_dim(dim_z);
    cfg.wrap_x = wrap_x;
    cfg.wrap_y = wrap_y;
    cfg.wrap_z = wrap_z;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) state <= tgs_pkg::ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tgs_pkg::ST_IDLE: begin
        if (accept && is_sample) state_next = tgs_pkg::ST_SETUP;
      end
      tgs_pkg::ST_SETUP: begin
        if (!acc_busy) state_next = tgs_pkg::ST_READ;
      end
      tgs_pkg::ST_READ: begin
        if (last_corner) state_next = tgs_pkg::ST_IDLE;
      end
      default: state_next = tgs_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ctl.load      = 1'b0;
    ctl.setup     = 1'b0;
    ctl.issue     = 1'b0;
    case (state)
      tgs_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        ctl.load      = s_axis_tvalid && is_sample;
      end
      tgs_pkg::ST_SETUP: ctl.setup = 1'b1;
      tgs_pkg::ST_READ:  ctl.issue = 1'b1;
      default: ;
    endcase
  end

  tgs_voxel_ram u_ram (
    .clk   (clk),
    .we    (accept && (s_axis_tuser == tgs_pkg::CMD_WRITE)),
    .waddr (voxel_index),
    .wdata (voxel_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  tgs_addr_gen u_addr_gen (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .ctl         (ctl),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .rd_addr     (rd_addr),
    .req         (req),
    .last_corner (last_corner)
  );

  tgs_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rd_data  ($signed(rd_data)),
    .busy     (acc_busy),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata)
  );

endmodule

// ----- design/tgs_voxel_ram.sv -----
// tgs_voxel_ram: voxel store, one write port and one registered read port
// depends on tgs_pkg for depth and data width
`timescale 1ns / 1ps

module tgs_voxel_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [tgs_pkg::ADDR_W-1:0]  waddr,
  input  logic [tgs_pkg::DATA_W-1:0]  wdata,
  input  logic [tgs_pkg::ADDR_W-1:0]  raddr,
  output logic [tgs_pkg::DATA_W-1:0]  rdata
);

  logic [tgs_pkg::DATA_W-1:0] mem [tgs_pkg::VOXEL_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- design/tgs_addr_gen.sv -----
// tgs_addr_gen: splits a sample position into floor and fraction, finds the
// corner coordinates and walks the eight corners; depends on tgs_pkg
`timescale 1ns / 1ps

module tgs_addr_gen (
  input  logic                                clk,
  input  logic                                rst,
  input  tgs_pkg::grid_cfg_t                  cfg,
  input  tgs_pkg::seq_ctl_t                   ctl,
  input  logic signed [tgs_pkg::POS_W-1:0]    pos_x,
  input  logic signed [tgs_pkg::POS_W-1:0]    pos_y,
  input  logic signed [tgs_pkg::POS_W-1:0]    pos_z,
  output logic [tgs_pkg::ADDR_W-1:0]          rd_addr,
  output tgs_pkg::term_req_t                  req,
  output logic                                last_corner
);

  localparam int FW  = tgs_pkg::FLOOR_W;
  localparam int FB  = tgs_pkg::FRAC_BITS;
  localparam int CW  = tgs_pkg::COORD_W;
  localparam int WW  = tgs_pkg::WGT_W;
  localparam int DW  = tgs_pkg::DIM_W;
  localparam int YW  = CW + DW;
  localparam int ZW  = CW + 2 * DW;
  localparam logic [WW-1:0] ONE = WW'(1) << FB;

  logic signed [FW-1:0]       fl_x, fl_y, fl_z;
  logic [FB-1:0]              fr_x, fr_y, fr_z;
  logic [CW-1:0]              c0_x, c1_x, c0_y, c1_y, c0_z, c1_z;
  logic [2*DW-1:0]            dxy;
  logic [tgs_pkg::CNT_W-1:0]  cnt;
  logic signed [FW:0]         lo_x, lo_y, lo_z;
  logic signed [FW:0]         hi_x, hi_y, hi_z;
  logic [CW-1:0]              cx, cy, cz;
  logic [YW-1:0]              off_y;
  logic [ZW-1:0]              off_z;
  logic [ZW-1:0]              lin;

  // capture floor and fraction of each axis when a sample is taken
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      fl_x <= pos_x[tgs_pkg::POS_W-1:FB];
      fl_y <= pos_y[tgs_pkg::POS_W-1:FB];
      fl_z <= pos_z[tgs_pkg::POS_W-1:FB];
      fr_x <= pos_x[FB-1:0];
      fr_y <= pos_y[FB-1:0];
      fr_z <= pos_z[FB-1:0];
    end
  end

  // low and high neighbor along each axis
  always_comb begin
    lo_x = {fl_x[FW-1], fl_x};
    lo_y = {fl_y[FW-1], fl_y};
    lo_z = {fl_z[FW-1], fl_z};
    hi_x = lo_x + (FW+1)'(1);
    hi_y = lo_y + (FW+1)'(1);
    hi_z = lo_z + (FW+1)'(1);
  end

  // corner coordinates and the plane stride
  always_ff @(posedge clk) begin
    if (ctl.setup) begin
      c0_x <= tgs_pkg::corner_coord(lo_x, cfg.dim_x, cfg.wrap_x);
      c1_x <= tgs_pkg::corner_coord(hi_x, cfg.dim_x, cfg.wrap_x);
      c0_y <= tgs_pkg::corner_coord(lo_y, cfg.dim_y, cfg.wrap_y);
      c1_y <= tgs_pkg::corner_coord(hi_y, cfg.dim_y, cfg.wrap_y);
      c0_z <= tgs_pkg::corner_coord(lo_z, cfg.dim_z, cfg.wrap_z);
      c1_z <= tgs_pkg::corner_coord(hi_z, cfg.dim_z, cfg.wrap_z);
      dxy  <= (2*DW)'(cfg.dim_x) * (2*DW)'(cfg.dim_y);
    end
  end

  // corner counter, bit 0 picks x, bit 1 y, bit 2 z
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.setup) begin
      cnt <= '0;
    end else if (ctl.issue) begin
      cnt <= cnt + tgs_pkg::CNT_W'(1);
    end
  end

  // linear address of the current corner; it stays below MAX_DIM cubed
  always_comb begin
    cx    = cnt[0] ? c1_x : c0_x;
    cy    = cnt[1] ? c1_y : c0_y;
    cz    = cnt[2] ? c1_z : c0_z;
    off_y = YW'(cy) * YW'(cfg.dim_x);
    off_z = ZW'(cz) * ZW'(dxy);
    lin   = ZW'(cx) + ZW'(off_y) + off_z;
    rd_addr = lin[tgs_pkg::ADDR_W-1:0];
  end

  // axis weights and term request
  always_comb begin
    last_corner = (cnt == tgs_pkg::CNT_W'(tgs_pkg::CORNERS - 1));
    req.valid = ctl.issue;
    req.first = (cnt == '0);
    req.last  = last_corner;
    req.wx    = cnt[0] ? {1'b0, fr_x} : (ONE - {1'b0, fr_x});
    req.wy    = cnt[1] ? {1'b0, fr_y} : (ONE - {1'b0, fr_y});
    req.wz    = cnt[2] ? {1'b0, fr_z} : (ONE - {1'b0, fr_z});
  end

  // corners must land inside the grid
  a_corner_in_grid: assert property (@(posedge clk) disable iff (rst)
    req.valid |-> ({1'b0, cx} < cfg.dim_x) && ({1'b0, cy} < cfg.dim_y) &&
                  ({1'b0, cz} < cfg.dim_z))
    else $error("corner coordinate outside the grid");

  // the first corner comes straight after setup
  a_first_after_setup: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.first |-> $past(ctl.setup))
    else $error("first corner issued without setup");

endmodule

// ----- design/tgs_accum.sv -----
// tgs_accum: weight multiply pipeline, eight-term accumulator, saturation and
// the result register of the output stream; depends on tgs_pkg
`timescale 1ns / 1ps

module tgs_accum (
  input  logic                               clk,
  input  logic                               rst,
  input  tgs_pkg::term_req_t                 req,
  input  logic signed [tgs_pkg::DATA_W-1:0]  rd_data,
  output logic                               busy,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tgs_pkg::DATA_W-1:0]         m_tdata
);

  localparam int FB = tgs_pkg::FRAC_BITS;
  localparam int WW = tgs_pkg::WGT_W;
  localparam int DW = tgs_pkg::DATA_W;
  localparam int TW = tgs_pkg::TERM_W;
  localparam int AW = tgs_pkg::ACC_W;
  localparam logic signed [AW-1:0] SAT_HI = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_LO = {{(AW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  logic                    s1_valid, s1_first, s1_last;
  logic [WW-1:0]           s1_wxy, s1_wz;
  logic                    s2_valid, s2_first, s2_last;
  logic [WW-1:0]           s2_wt;
  logic signed [DW-1:0]    s2_val;
  logic                    s3_valid, s3_first, s3_last;
  logic signed [TW-1:0]    s3_term;
  logic signed [AW-1:0]    acc, acc_next;
  logic                    done, done_next;
  logic                    out_load;
  logic [2*WW-1:0]         prod_xy, prod_t;
  logic signed [WW+DW:0]   prod_v;
  logic signed [AW-1:0]    sat;

  assign prod_xy = (2*WW)'(req.wx) * (2*WW)'(req.wy);
  assign prod_t  = (2*WW)'(s1_wxy) * (2*WW)'(s1_wz);
  assign prod_v  = (WW+DW+1)'($signed({1'b0, s2_wt})) * (WW+DW+1)'(s2_val);

  // valid and framing flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= req.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // stage 1: x by y weight; stage 2: times z, voxel arrives from the store;
  // stage 3: weighted value, floor of the fixed-point shift
  always_ff @(posedge clk) begin
    s1_first <= req.first;
    s1_last  <= req.last;
    s1_wxy   <= prod_xy[FB +: WW];
    s1_wz    <= req.wz;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_wt    <= prod_t[FB +: WW];
    s2_val   <= rd_data;
    s3_first <= s2_first;
    s3_last  <= s2_last;
    s3_term  <= prod_v[FB +: TW];
  end

  // running sum, restarted by the first corner of a sample
  always_comb begin
    acc_next = acc;
    if (s3_valid) begin
      acc_next = (s3_first ? '0 : acc) + {{(AW-TW){s3_term[TW-1]}}, s3_term};
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  // finished sum waits here until the result register is free
  always_comb begin
    out_load  = done && (!m_tvalid || m_tready);
    done_next = done;
    if (out_load) done_next = 1'b0;
    if (s3_valid && s3_last) done_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= done_next;
  end

  // saturate to the 32-bit signed range
  always_comb begin
    if (acc > SAT_HI) sat = SAT_HI;
    else if (acc < SAT_LO) sat = SAT_LO;
    else sat = acc;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) m_tdata <= sat[DW-1:0];
  end

  assign busy = s1_valid || s2_valid || s3_valid || done;

  // a new sample only enters an empty pipeline
  a_first_into_empty: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.first |-> !s1_valid && !s2_valid && !s3_valid && !done)
    else $error("sample started while the previous one was in flight");

  // the last term always leaves a finished sum behind
  a_last_sets_done: assert property (@(posedge clk) disable iff (rst)
    s3_valid && s3_last |=> done)
    else $error("last term did not complete the sum");

  // a finished sum moves out as soon as the result register frees up
  a_done_drains: assert property (@(posedge clk) disable iff (rst)
    done && (!m_tvalid || m_tready) |=> m_tvalid && !done)
    else $error("finished sum not moved to the result register");

  // a result only appears from a finished sum
  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(done))
    else $error("result raised without a finished sum");

endmodule

// ----- tb/trilinear_grid_sampler_top_test.sv -----
// trilinear_grid_sampler_top_test: self-checking bench for the trilinear grid sampler,
// with a scoreboard class that predicts every sample from its own copy of the voxel grid
// depends on tgs_pkg and trilinear_grid_sampler_top
`timescale 1ns / 1ps

module trilinear_grid_sampler_top_test;
  import tgs_pkg::*;

  localparam int RESET_CYCLES    = 12;
  localparam int SETTLE_CYCLES   = 24;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int ITEMS_PER_PHASE = 90;
  localparam int NUM_SETTINGS    = 8;
  localparam int MAX_REPORTS     = 10;
  localparam int PAD_W           = TDATA_W - (ADDR_W + DATA_W + 3 * POS_W);
  localparam longint Q_ONE       = longint'(1) << FRAC_BITS;

  // register indexes that the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // scoreboard: grid copy, register copy and the queue of predicted samples
  class trilinear_scoreboard;
    logic [DATA_W-1:0] voxels [VOXEL_DEPTH];
    bit                written [VOXEL_DEPTH];
    logic [DIM_W-1:0]  dim [3];
    logic              wrap [3];
    logic [DATA_W-1:0] pending_samples [$];
    int                mismatches;
    int                checked;

    function new();
      for (int a = 0; a < 3; a++) begin
        dim[a]  = DIM_W'(16);
        wrap[a] = 1'b0;
      end
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      case (idx)
        REG_DIM_X:  dim[0]  = data;
        REG_DIM_Y:  dim[1]  = data;
        REG_DIM_Z:  dim[2]  = data;
        REG_WRAP_X: wrap[0] = data[0];
        REG_WRAP_Y: wrap[1] = data[0];
        REG_WRAP_Z: wrap[2] = data[0];
        default: ;
      endcase
    endfunction

    // grid size actually used: 2..MAX_DIM
    function int grid_size(logic [DIM_W-1:0] d);
      int r;
      r = int'(d);
      if (r < 2) r = 2;
      if (r > MAX_DIM) r = MAX_DIM;
      return r;
    endfunction

    // linear address of corner k (bit 0 x, bit 1 y, bit 2 z picks floor + 1)
    function int corner_addr(int k, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                             logic [POS_W-1:0] pz);
      logic [POS_W-1:0] p [3];
      int d, c, addr, stride, a;
      p[0] = px;
      p[1] = py;
      p[2] = pz;
      addr   = 0;
      stride = 1;
      for (a = 0; a < 3; a++) begin
        d = grid_size(dim[a]);
        c = int'($signed(p[a][POS_W-1:FRAC_BITS])) + ((k >> a) & 1);
        if (wrap[a]) begin
          c = c % d;
          if (c < 0) c = c + d;
        end else if (c < 0) begin
          c = 0;
        end else if (c > d - 1) begin
          c = d - 1;
        end
        addr   = addr + c * stride;
        stride = stride * d;
      end
      return addr;
    endfunction

    // weighted sum of the eight corners, floor shifts, saturated to 32 bits
    function logic [DATA_W-1:0] interpolate(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                            logic [POS_W-1:0] pz);
      logic [POS_W-1:0] p [3];
      longint wgt [3][2];
      longint wxy, wt, val, acc;
      int addr, a, k;
      p[0] = px;
      p[1] = py;
      p[2] = pz;
      for (a = 0; a < 3; a++) begin
        wgt[a][1] = longint'(p[a][FRAC_BITS-1:0]);
        wgt[a][0] = Q_ONE - wgt[a][1];
      end
      acc = 0;
      for (k = 0; k < CORNERS; k++) begin
        wxy  = (wgt[0][k & 1] * wgt[1][(k >> 1) & 1]) >>> FRAC_BITS;
        wt   = (wxy * wgt[2][(k >> 2) & 1]) >>> FRAC_BITS;
        addr = corner_addr(k, px, py, pz);
        val  = written[addr] ? longint'($signed(voxels[addr])) : 0;
        acc  = acc + ((wt * val) >>> FRAC_BITS);
      end
      if (acc > longint'(32'sh7FFF_FFFF)) acc = longint'(32'sh7FFF_FFFF);
      if (acc < -(longint'(1) << 31)) acc = -(longint'(1) << 31);
      return acc[DATA_W-1:0];
    endfunction

    function void note_request(logic cmd, logic [ADDR_W-1:0] idx, logic [DATA_W-1:0] val,
                               logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                               logic [POS_W-1:0] pz);
      if (cmd == CMD_WRITE) begin
        voxels[idx]  = val;
        written[idx] = 1'b1;
      end else begin
        pending_samples.insert(pending_samples.size(), interpolate(px, py, pz));
      end
    endfunction

    function void check_sample(logic [DATA_W-1:0] got);
      logic [DATA_W-1:0] want;
      checked++;
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result %0d with no sample request pending", $realtime,
                   $signed(got));
      end else begin
        want = pending_samples.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] sample_value mismatch: expected %0d, got %0d", $realtime,
                     $signed(want), $signed(got));
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata = '0;
  logic                 s_axis_tuser = CMD_WRITE;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_W-1:0]    m_axis_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DIM_X;
  logic [DIM_W-1:0]     cfg_data = '0;

  trilinear_scoreboard sb;
  int src_idle_pct = 10;
  int dst_idle_pct = 64;
  int cycle_count  = 0;
  int n_writes     = 0;
  int n_samples    = 0;
  int n_reg_writes = 0;

  trilinear_grid_sampler_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: check accepted results, stall at random
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_sample(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  // voxel values: extremes, small numbers, anything
  function automatic logic [DATA_W-1:0] rand_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(7))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2: v = DATA_W'(int'($urandom_range(2000)) - 1000);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // positions mostly near the grid, some anywhere in the field
  function automatic logic [POS_W-1:0] rand_pos(int d);
    int fl, p;
    logic [FRAC_BITS-1:0] fr;
    logic [POS_W-1:0] res;
    fl = 0;
    fr = '0;
    case ($urandom_range(9))
      0: ;
      1: fl = int'($urandom_range(d + 3)) - 2;
      2: begin
        fl = int'($urandom_range(d + 1)) - 1;
        fr = '1;
      end
      default: begin
        fl = int'($urandom_range(d + 1)) - 1;
        fr = FRAC_BITS'($urandom);
      end
    endcase
    p   = fl * int'(Q_ONE) + int'(fr);
    res = p[POS_W-1:0];
    if (fl == 0 && fr == '0) res = POS_W'($urandom);
    return res;
  endfunction

  // one request through the slave side
  task automatic send_request(input logic cmd, input logic [ADDR_W-1:0] idx,
                              input logic [DATA_W-1:0] val, input logic [POS_W-1:0] px,
                              input logic [POS_W-1:0] py, input logic [POS_W-1:0] pz);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{PAD_W{1'b0}}, pz, py, px, val, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(cmd, idx, val, px, py, pz);
    if (cmd == CMD_WRITE) n_writes++;
    else n_samples++;
  endtask

  task automatic send_write(input logic [ADDR_W-1:0] idx, input logic [DATA_W-1:0] val);
    send_request(CMD_WRITE, idx, val, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
  endtask

  // sample, first filling any corner voxel that was never stored
  task automatic sample_at(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                           input logic [POS_W-1:0] pz);
    int addr;
    for (int k = 0; k < CORNERS; k++) begin
      addr = sb.corner_addr(k, px, py, pz);
      if (!sb.written[addr]) send_write(ADDR_W'(addr), rand_value());
    end
    send_request(CMD_SAMPLE, ADDR_W'($urandom), $urandom, px, py, pz);
  endtask

  // give all eight corners of a position one value
  task automatic paint_corners(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                               input logic [POS_W-1:0] pz, input logic [DATA_W-1:0] val);
    for (int k = 0; k < CORNERS; k++) send_write(ADDR_W'(sb.corner_addr(k, px, py, pz)), val);
  endtask

  // hold requests until every sample has been answered and the block is quiet
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write; the caller lowers cfg_we after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    n_reg_writes++;
  endtask

  task automatic apply_setting(input logic [DIM_W-1:0] dx, input logic [DIM_W-1:0] dy,
                               input logic [DIM_W-1:0] dz, input logic [DIM_W-1:0] wx,
                               input logic [DIM_W-1:0] wy, input logic [DIM_W-1:0] wz);
    drain_results();
    write_reg(REG_DIM_X, dx);
    write_reg(REG_DIM_Y, dy);
    write_reg(REG_DIM_Z, dz);
    write_reg(REG_WRAP_X, wx);
    write_reg(REG_WRAP_Y, wy);
    write_reg(REG_WRAP_Z, wz);
    write_reg(REG_SPARE_LO, DIM_W'($urandom));
    write_reg(REG_SPARE_HI, DIM_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // mostly samples with fresh corners, some stray writes, one full pause midway
  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain_results();
      if ($urandom_range(99) < 30)
        send_write(ADDR_W'($urandom_range(VOXEL_DEPTH - 1)), rand_value());
      else
        sample_at(rand_pos(sb.grid_size(sb.dim[0])), rand_pos(sb.grid_size(sb.dim[1])),
                  rand_pos(sb.grid_size(sb.dim[2])));
    end
  endtask

  // sender and receiver idling, changed every third phase
  task automatic set_idling(input int phase);
    case (phase / 3)
      0: begin
        src_idle_pct = 10;
        dst_idle_pct = 64;
      end
      1: begin
        src_idle_pct = 64;
        dst_idle_pct = 10;
      end
      default: begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
    endcase
  endtask

  // main sequence
  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part under the reset setting (16 cubed, clamping)
    set_idling(0);
    send_write(ADDR_W'(0), 32'h7FFF_FFFF);
    send_write(ADDR_W'(VOXEL_DEPTH - 1), 32'h8000_0000);
    sample_at(POS_W'(0), POS_W'(0), POS_W'(0));
    sample_at(POS_W'(1114111), POS_W'(1114111), POS_W'(1114111));
    sample_at(POS_W'(-65536), POS_W'(-65536), POS_W'(-65536));
    sample_at(22'h1F_FFFF, 22'h20_0000, 22'h1F_FFFF);
    sample_at(22'h20_0000, 22'h1F_FFFF, 22'h20_0000);
    // upper corner clamped onto the lower one
    sample_at(POS_W'(15 * 65536 + 32768), POS_W'(16384), POS_W'(15 * 65536 + 1));
    paint_corners(POS_W'(7 * 65536 + 32768), POS_W'(7 * 65536 + 32768),
                  POS_W'(7 * 65536 + 32768), 32'h8000_0000);
    sample_at(POS_W'(7 * 65536 + 32768), POS_W'(7 * 65536 + 32768),
              POS_W'(7 * 65536 + 32768));
    paint_corners(POS_W'(3 * 65536 + 65535), POS_W'(2 * 65536 + 1),
                  POS_W'(9 * 65536 + 65535), 32'h7FFF_FFFF);
    sample_at(POS_W'(3 * 65536 + 65535), POS_W'(2 * 65536 + 1), POS_W'(9 * 65536 + 65535));
    // store right before a sample that reads it
    send_write(ADDR_W'(sb.corner_addr(0, POS_W'(5 << 16), POS_W'(5 << 16), POS_W'(5 << 16))),
               32'hFFFF_FFFF);
    sample_at(POS_W'(5 << 16), POS_W'(5 << 16), POS_W'(5 << 16));

    run_random(ITEMS_PER_PHASE);

    for (int s = 1; s <= NUM_SETTINGS; s++) begin
      case (s)
        1: apply_setting(5'd2, 5'd2, 5'd2, 5'd1, 5'd1, 5'd1);
        2: apply_setting(5'd16, 5'd16, 5'd16, 5'd0, 5'd0, 5'd0);
        3: apply_setting(5'd0, 5'd1, 5'd31, 5'b00001, 5'b11110, 5'b10101);
        4: apply_setting(5'd3, 5'd5, 5'd7, 5'd0, 5'd1, 5'd0);
        5: apply_setting(5'd16, 5'd2, 5'd16, 5'd1, 5'd1, 5'd0);
        8: apply_setting(5'd2, 5'd16, 5'd3, 5'd0, 5'd0, 5'd1);
        default: apply_setting(DIM_W'($urandom), DIM_W'($urandom), DIM_W'($urandom),
                               DIM_W'($urandom), DIM_W'($urandom), DIM_W'($urandom));
      endcase
      set_idling(s);
      run_random(ITEMS_PER_PHASE);
    end

    drain_results();
    $display("ran %0d writes and %0d samples over %0d settings (%0d register writes)",
             n_writes, n_samples, NUM_SETTINGS + 1, n_reg_writes);
    $display("checked %0d results, %0d mismatches, %0d samples unanswered",
             sb.checked, sb.mismatches, sb.pending_samples.size());
    if (sb.mismatches == 0 && sb.pending_samples.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
